/* hdl/dsched_pkg.sv */
// Shared types and constants of the disk request scheduler.
// No dependencies; used by dsched_cell and the top level.
`default_nettype none

package dsched_pkg;

  // Fixed field widths of the ports
  localparam int BLOCK_W     = 31;
  localparam int PORT_TAG_W  = 16;
  localparam int COUNT_OUT_W = 5;

  // Parameter defaults
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TAG_WIDTH_DEF   = 16;

  // Input word kinds
  localparam logic KIND_ENQUEUE = 1'b0;
  localparam logic KIND_PICK    = 1'b1;

  // Policy register codes
  localparam logic POLICY_FCFS = 1'b0;
  localparam logic POLICY_SSTF = 1'b1;

  // Per-cell control, decoded once in the top level
  typedef struct packed {
    logic occupied;  // cell holds a pending request
    logic load;      // write the incoming request into this cell
    logic shift;     // take the entry of the next cell
    logic sstf;      // nearest-block policy active
  } cell_ctl_t;

  // Search record handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic [BLOCK_W-1:0] distance;
    logic [BLOCK_W-1:0] block;
    logic               write;
  } seek_rec_t;

endpackage

`default_nettype wire

/* hdl/dsched_cell.sv */
// One queue slot of the disk request scheduler with its stage of the search chain.
// Depends on dsched_pkg.
`default_nettype none

module dsched_cell #(
  parameter int QUEUE_DEPTH = dsched_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_WIDTH   = dsched_pkg::TAG_WIDTH_DEF,
  parameter int IDX         = 0
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  dsched_pkg::cell_ctl_t                  ctl,
  input  wire  [dsched_pkg::BLOCK_W-1:0]         head,
  input  wire  [dsched_pkg::BLOCK_W-1:0]         ld_block,
  input  wire                                    ld_write,
  input  wire  [TAG_WIDTH-1:0]                   ld_tag,
  input  wire  [dsched_pkg::BLOCK_W-1:0]         nbr_block,
  input  wire                                    nbr_write,
  input  wire  [TAG_WIDTH-1:0]                   nbr_tag,
  output logic [dsched_pkg::BLOCK_W-1:0]         ent_block,
  output logic                                   ent_write,
  output logic [TAG_WIDTH-1:0]                   ent_tag,
  input  dsched_pkg::seek_rec_t                  rec_in,
  input  wire  [$clog2(QUEUE_DEPTH)-1:0]         rec_idx_in,
  input  wire  [TAG_WIDTH-1:0]                   rec_tag_in,
  output dsched_pkg::seek_rec_t                  rec_out,
  output logic [$clog2(QUEUE_DEPTH)-1:0]         rec_idx_out,
  output logic [TAG_WIDTH-1:0]                   rec_tag_out
);

  localparam int   IDX_W   = $clog2(QUEUE_DEPTH);
  localparam logic IS_HEAD = (IDX == 0);

  logic [dsched_pkg::BLOCK_W-1:0] block_r;
  logic                           write_r;
  logic [TAG_WIDTH-1:0]           tag_r;

  dsched_pkg::seek_rec_t          rec_r;
  logic [IDX_W-1:0]               rec_idx_r;
  logic [TAG_WIDTH-1:0]           rec_tag_r;

  logic [dsched_pkg::BLOCK_W:0]   diff_fwd;
  logic [dsched_pkg::BLOCK_W-1:0] diff_rev;
  logic [dsched_pkg::BLOCK_W-1:0] own_dist;
  logic                           take;

  // Distance from the head, absolute value
  always_comb begin
    diff_fwd = {1'b0, block_r} - {1'b0, head};
    diff_rev = head - block_r;
    own_dist = diff_fwd[dsched_pkg::BLOCK_W] ? diff_rev : diff_fwd[dsched_pkg::BLOCK_W-1:0];
  end

  // Strict compare keeps the earlier entry on a tie
  assign take = rec_in.valid && ctl.occupied &&
                (IS_HEAD || (ctl.sstf && (own_dist < rec_in.distance)));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      block_r <= ld_block;
      write_r <= ld_write;
      tag_r   <= ld_tag;
    end else if (ctl.shift) begin
      block_r <= nbr_block;
      write_r <= nbr_write;
      tag_r   <= nbr_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r.valid <= 1'b0;
    end else begin
      rec_r.valid <= rec_in.valid;
    end
    if (take) begin
      rec_r.distance <= own_dist;
      rec_r.block    <= block_r;
      rec_r.write    <= write_r;
      rec_idx_r      <= IDX_W'(IDX);
      rec_tag_r      <= tag_r;
    end else begin
      rec_r.distance <= rec_in.distance;
      rec_r.block    <= rec_in.block;
      rec_r.write    <= rec_in.write;
      rec_idx_r      <= rec_idx_in;
      rec_tag_r      <= rec_tag_in;
    end
  end

  assign ent_block   = block_r;
  assign ent_write   = write_r;
  assign ent_tag     = tag_r;
  assign rec_out     = rec_r;
  assign rec_idx_out = rec_idx_r;
  assign rec_tag_out = rec_tag_r;

endmodule

`default_nettype wire

/* hdl/disk_request_scheduler_fcfs_sstf.sv */
// Top level of the disk request scheduler: controller and the row of queue cells.
// Depends on dsched_pkg and dsched_cell.
//
// Holds up to QUEUE_DEPTH pending disk requests in arrival order, one per cell,
// oldest in cell 0. Every accepted word yields exactly one result word. An
// enqueue word is stored (or rejected when the queue is full) and its result
// is registered in the cycle after acceptance. A pick word sends a search
// record down the row of cells, one cell per cycle; each occupied cell replaces
// the record with its own entry when it is nearer the head (SSTF) or when it is
// cell 0. When the record leaves the last cell, the cells behind the winner
// shift one place toward cell 0 and the result is registered; a pick passes the
// start register, each cell's record register and the result register. A pick
// on an empty queue has its result registered in the cycle after acceptance.
// One word is in flight at a time; the next word is taken once the result register
// is free or being drained. The user must write the policy register through
// cfg_wr_en / cfg_wr_data while the block is idle; the block does not check it.
`default_nettype none

module disk_request_scheduler_fcfs_sstf #(
  parameter int QUEUE_DEPTH = dsched_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_WIDTH   = dsched_pkg::TAG_WIDTH_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // configuration
  input  wire                                   cfg_wr_en,
  input  wire                                   cfg_wr_data,
  // input words
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire                                   in_kind,
  input  wire  [dsched_pkg::BLOCK_W-1:0]        in_block_number,
  input  wire                                   in_write_flag,
  input  wire  [dsched_pkg::PORT_TAG_W-1:0]     in_request_tag,
  // result words
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic                                  out_issued,
  output logic [dsched_pkg::BLOCK_W-1:0]        out_issued_block,
  output logic                                  out_issued_write,
  output logic [dsched_pkg::PORT_TAG_W-1:0]     out_issued_tag,
  output logic                                  out_rejected,
  output logic [dsched_pkg::COUNT_OUT_W-1:0]    out_pending_count
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  state_t                   state_r;
  logic [CNT_W-1:0]         count_r;
  logic [dsched_pkg::BLOCK_W-1:0] head_r;
  logic                     policy_r;
  logic                     start_r;

  logic                     out_valid_r;
  logic                     out_issued_r;
  logic [dsched_pkg::BLOCK_W-1:0] out_block_r;
  logic                     out_write_r;
  logic [dsched_pkg::PORT_TAG_W-1:0] out_tag_r;
  logic                     out_rejected_r;
  logic [dsched_pkg::COUNT_OUT_W-1:0] out_pending_r;

  logic                     in_accept;
  logic                     out_take;
  logic                     full;
  logic                     enq_ok;
  logic                     done;
  logic [TAG_WIDTH-1:0]     in_tag_ext;

  // Chain wiring: index g carries the record leaving cell g-1 (0 is the injector)
  dsched_pkg::cell_ctl_t    ctl      [QUEUE_DEPTH];
  dsched_pkg::seek_rec_t    rec      [QUEUE_DEPTH+1];
  logic [IDX_W-1:0]         rec_idx  [QUEUE_DEPTH+1];
  logic [TAG_WIDTH-1:0]     rec_tag  [QUEUE_DEPTH+1];
  logic [dsched_pkg::BLOCK_W-1:0] ent_block [QUEUE_DEPTH+1];
  logic                     ent_write [QUEUE_DEPTH+1];
  logic [TAG_WIDTH-1:0]     ent_tag   [QUEUE_DEPTH+1];

  // Accept only when idle and the result register is free or draining
  assign out_take  = out_valid_r && !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign enq_ok     = in_accept && (in_kind == dsched_pkg::KIND_ENQUEUE) && !full;
  assign done       = (state_r == ST_SEARCH) && rec[QUEUE_DEPTH].valid;
  assign in_tag_ext = TAG_WIDTH'(in_request_tag);

  // Inject the search record into cell 0; its other fields are never chosen
  always_comb begin
    rec[0]       = '0;
    rec[0].valid = start_r;
    rec_idx[0]   = '0;
    rec_tag[0]   = '0;
  end

  // The last cell has no neighbor; feed zeros
  assign ent_block[QUEUE_DEPTH] = '0;
  assign ent_write[QUEUE_DEPTH] = 1'b0;
  assign ent_tag[QUEUE_DEPTH]   = '0;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    always_comb begin
      ctl[g].occupied = (CNT_W'(g) < count_r);
      ctl[g].load     = enq_ok && (count_r == CNT_W'(g));
      // Close the gap left by the issued entry
      ctl[g].shift    = done && (IDX_W'(g) >= rec_idx[QUEUE_DEPTH]);
      ctl[g].sstf     = (policy_r == dsched_pkg::POLICY_SSTF);
    end

    dsched_cell #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TAG_WIDTH   (TAG_WIDTH),
      .IDX         (g)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl[g]),
      .head        (head_r),
      .ld_block    (in_block_number),
      .ld_write    (in_write_flag),
      .ld_tag      (in_tag_ext),
      .nbr_block   (ent_block[g+1]),
      .nbr_write   (ent_write[g+1]),
      .nbr_tag     (ent_tag[g+1]),
      .ent_block   (ent_block[g]),
      .ent_write   (ent_write[g]),
      .ent_tag     (ent_tag[g]),
      .rec_in      (rec[g]),
      .rec_idx_in  (rec_idx[g]),
      .rec_tag_in  (rec_tag[g]),
      .rec_out     (rec[g+1]),
      .rec_idx_out (rec_idx[g+1]),
      .rec_tag_out (rec_tag[g+1])
    );
  end

  // Controller: state, queue count, head position and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      count_r        <= '0;
      head_r         <= '0;
      policy_r       <= dsched_pkg::POLICY_FCFS;
      start_r        <= 1'b0;
      out_valid_r    <= 1'b0;
      out_issued_r   <= 1'b0;
      out_block_r    <= '0;
      out_write_r    <= 1'b0;
      out_tag_r      <= '0;
      out_rejected_r <= 1'b0;
      out_pending_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        policy_r <= cfg_wr_data;
      end
      start_r <= 1'b0;
      if (out_take) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            if (in_kind == dsched_pkg::KIND_ENQUEUE) begin
              // Store or drop, answer at once
              out_valid_r    <= 1'b1;
              out_issued_r   <= 1'b0;
              out_block_r    <= '0;
              out_write_r    <= 1'b0;
              out_tag_r      <= '0;
              out_rejected_r <= full;
              if (full) begin
                out_pending_r <= dsched_pkg::COUNT_OUT_W'(count_r);
              end else begin
                count_r       <= count_r + 1'b1;
                out_pending_r <= dsched_pkg::COUNT_OUT_W'(count_r + 1'b1);
              end
            end else if (count_r == '0) begin
              // Pick on an empty queue: all-zero result
              out_valid_r    <= 1'b1;
              out_issued_r   <= 1'b0;
              out_block_r    <= '0;
              out_write_r    <= 1'b0;
              out_tag_r      <= '0;
              out_rejected_r <= 1'b0;
              out_pending_r  <= '0;
            end else begin
              // Launch the search down the cell row
              start_r <= 1'b1;
              state_r <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          if (rec[QUEUE_DEPTH].valid) begin
            // Issue the winner, move the head, drop one entry
            out_valid_r    <= 1'b1;
            out_issued_r   <= 1'b1;
            out_block_r    <= rec[QUEUE_DEPTH].block;
            out_write_r    <= rec[QUEUE_DEPTH].write;
            out_tag_r      <= dsched_pkg::PORT_TAG_W'(rec_tag[QUEUE_DEPTH]);
            out_rejected_r <= 1'b0;
            out_pending_r  <= dsched_pkg::COUNT_OUT_W'(count_r - 1'b1);
            head_r         <= rec[QUEUE_DEPTH].block;
            count_r        <= count_r - 1'b1;
            state_r        <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_issued        = out_issued_r;
  assign out_issued_block  = out_block_r;
  assign out_issued_write  = out_write_r;
  assign out_issued_tag    = out_tag_r;
  assign out_rejected      = out_rejected_r;
  assign out_pending_count = out_pending_r;

endmodule

`default_nettype wire

/* sim/tb_disk_request_scheduler_fcfs_sstf.sv */
// Testbench of disk_request_scheduler_fcfs_sstf: directed and random request/pick words,
// checked against a queue-based scheduler model kept in a small scoreboard class.
// Depends on dsched_pkg and the scheduler RTL; self-contained otherwise.
module tb_disk_request_scheduler_fcfs_sstf;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   BLOCK_W         = dsched_pkg::BLOCK_W;
  localparam int   PORT_TAG_W      = dsched_pkg::PORT_TAG_W;
  localparam int   COUNT_OUT_W     = dsched_pkg::COUNT_OUT_W;
  localparam int   QUEUE_DEPTH_DEF = dsched_pkg::QUEUE_DEPTH_DEF;
  localparam logic KIND_ENQUEUE    = dsched_pkg::KIND_ENQUEUE;
  localparam logic KIND_PICK       = dsched_pkg::KIND_PICK;
  localparam logic POLICY_FCFS     = dsched_pkg::POLICY_FCFS;
  localparam logic POLICY_SSTF     = dsched_pkg::POLICY_SSTF;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 7;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_WORDS   = 180;
  localparam int LONG_HOLD     = 400;    // receiver hold-off that backs the block up
  localparam int HOLD_AFTER    = 300;    // results seen before the hold-off starts
  localparam int SETTLE_CYCLES = 4;
  localparam int END_WAIT      = QUEUE_DEPTH_DEF + 8;
  localparam int TIMEOUT_NS    = 10_000_000;

  localparam logic [BLOCK_W-1:0] BLOCK_MAX = {BLOCK_W{1'b1}};

  // One result word as the block presents it
  typedef struct packed {
    logic                   issued;
    logic [BLOCK_W-1:0]     block;
    logic                   write;
    logic [PORT_TAG_W-1:0]  tag;
    logic                   rejected;
    logic [COUNT_OUT_W-1:0] count;
  } sched_result_t;

  // Scoreboard: keeps its own copy of the pending requests, the head position and
  // the policy, predicts one result per accepted word and checks results in order.
  class sched_scoreboard;
    logic                  sstf_mode = POLICY_FCFS;
    logic [BLOCK_W-1:0]    head_pos  = '0;
    logic [BLOCK_W-1:0]    pend_block[$];
    logic                  pend_write[$];
    logic [PORT_TAG_W-1:0] pend_tag[$];
    sched_result_t         expected_q[$];
    int unsigned           errors       = 0;
    int unsigned           results_seen = 0;

    function void set_policy(logic p);
      sstf_mode = p;
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction

    function logic [BLOCK_W-1:0] seek_dist(logic [BLOCK_W-1:0] a, logic [BLOCK_W-1:0] b);
      return (a > b) ? a - b : b - a;
    endfunction

    // Apply one accepted word to the model and queue the result it must produce
    function void note_word(logic kind, logic [BLOCK_W-1:0] blk, logic wr,
                            logic [PORT_TAG_W-1:0] tag);
      sched_result_t      r;
      int                 sel;
      logic [BLOCK_W-1:0] best;
      logic [BLOCK_W-1:0] d;
      r   = '0;
      sel = 0;
      if (kind == KIND_ENQUEUE) begin
        if (pend_block.size() >= QUEUE_DEPTH_DEF) begin
          r.rejected = 1'b1;
        end else begin
          pend_block.push_back(blk);
          pend_write.push_back(wr);
          pend_tag.push_back(tag);
        end
      end else if (pend_block.size() != 0) begin
        if (sstf_mode == POLICY_SSTF) begin
          // strict compare keeps the earliest entry on a tie
          best = seek_dist(pend_block[0], head_pos);
          for (int i = 1; i < pend_block.size(); i++) begin
            d = seek_dist(pend_block[i], head_pos);
            if (d < best) begin
              best = d;
              sel  = i;
            end
          end
        end
        r.issued = 1'b1;
        r.block  = pend_block[sel];
        r.write  = pend_write[sel];
        r.tag    = pend_tag[sel];
        head_pos = pend_block[sel];
        pend_block.delete(sel);
        pend_write.delete(sel);
        pend_tag.delete(sel);
      end
      r.count = COUNT_OUT_W'(pend_block.size());
      expected_q.push_back(r);
    endfunction

    function void field_check(string name, logic [BLOCK_W-1:0] want, logic [BLOCK_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(sched_result_t got);
      sched_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: result word with nothing expected, expected none actual %h", $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        field_check("issued", want.issued, got.issued);
        field_check("issued_block", want.block, got.block);
        field_check("issued_write", want.write, got.write);
        field_check("issued_tag", want.tag, got.tag);
        field_check("rejected", want.rejected, got.rejected);
        field_check("pending_count", want.count, got.count);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic                   cfg_wr_data;
  logic                   in_valid;
  logic                   in_stall;
  logic                   in_kind;
  logic [BLOCK_W-1:0]     in_block_number;
  logic                   in_write_flag;
  logic [PORT_TAG_W-1:0]  in_request_tag;
  logic                   out_valid;
  logic                   out_stall;
  logic                   out_issued;
  logic [BLOCK_W-1:0]     out_issued_block;
  logic                   out_issued_write;
  logic [PORT_TAG_W-1:0]  out_issued_tag;
  logic                   out_rejected;
  logic [COUNT_OUT_W-1:0] out_pending_count;

  sched_scoreboard sb = new;

  disk_request_scheduler_fcfs_sstf DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_block_number   (in_block_number),
    .in_write_flag     (in_write_flag),
    .in_request_tag    (in_request_tag),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_issued        (out_issued),
    .out_issued_block  (out_issued_block),
    .out_issued_write  (out_issued_write),
    .out_issued_tag    (out_issued_tag),
    .out_rejected      (out_rejected),
    .out_pending_count (out_pending_count)
  );

  always #(CLK_HALF) clk = ~clk;

  // Monitor both channels at the edge. Check the result first: a result that
  // leaves at the same edge as a new word is taken belongs to the previous word.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_word({out_issued, out_issued_block, out_issued_write, out_issued_tag,
                       out_rejected, out_pending_count});
      end
      if (in_valid && !in_stall) begin
        sb.note_word(in_kind, in_block_number, in_write_flag, in_request_tag);
      end
    end
  end

  // Offer one word and hold it until the edge that takes it
  task automatic send_word(input logic kind, input logic [BLOCK_W-1:0] blk, input logic wr,
                           input logic [PORT_TAG_W-1:0] tag);
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_block_number <= blk;
    in_write_flag   <= wr;
    in_request_tag  <= tag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic enqueue(input logic [BLOCK_W-1:0] blk, input logic wr,
                         input logic [PORT_TAG_W-1:0] tag);
    send_word(KIND_ENQUEUE, blk, wr, tag);
  endtask

  // Fill the ignored fields of a pick with noise
  task automatic pick();
    send_word(KIND_PICK, BLOCK_W'($urandom()), 1'($urandom()), PORT_TAG_W'($urandom()));
  endtask

  task automatic hold_input(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the policy register; the block is idle here, so the model switches at once
  task automatic write_policy(input logic p);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= p;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_policy(p);
  endtask

  // One random word. Blocks cluster in a narrow range and around the head so
  // that seek ties and equal blocks turn up, with extremes and full-range values.
  task automatic send_random(input int enq_pct);
    logic               kind;
    logic [BLOCK_W-1:0] blk;
    kind = ($urandom_range(0, 99) < enq_pct) ? KIND_ENQUEUE : KIND_PICK;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: blk = BLOCK_W'($urandom_range(0, 31));
      4, 5:       blk = sb.head_pos ^ BLOCK_W'($urandom_range(0, 7));
      6:          blk = $urandom_range(0, 1) ? BLOCK_MAX : '0;
      default:    blk = BLOCK_W'($urandom());
    endcase
    send_word(kind, blk, 1'($urandom()), PORT_TAG_W'($urandom()));
  endtask

  // Random phase: bursts of words with a per-burst enqueue bias, so the queue
  // swings between empty and full. Some phases run with no gaps at all.
  task automatic run_phase(input int words);
    int burst_left;
    int gap;
    int enq_pct;
    bit gapless;
    gapless    = ($urandom_range(0, 3) == 0);
    burst_left = 0;
    enq_pct    = 50;
    repeat (words) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        case ($urandom_range(0, 2))
          0:       enq_pct = 20;
          1:       enq_pct = 50;
          default: enq_pct = 90;
        endcase
        if (gapless) begin
          gap = 0;
        end else if ($urandom_range(0, 3) == 0) begin
          gap = $urandom_range(5, 30);
        end else begin
          gap = $urandom_range(0, 3);
        end
        if (gap > 0) hold_input(gap);
      end
      send_random(enq_pct);
      burst_left--;
    end
  endtask

  // Receiver pacing: segments of random length, each with its own stall pattern.
  // Once, after enough results, hold off for a long stretch while the sender
  // keeps offering, so the block backs up and stalls its input.
  initial begin : rx_pace
    int seg;
    int mode;
    bit long_hold_done;
    long_hold_done = 1'b0;
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!long_hold_done && sb.results_seen >= HOLD_AFTER) begin
        // Keep draining while the sender is quiet
        out_stall <= 1'b0;
        while (!in_valid) @(posedge clk);
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      seg  = $urandom_range(16, 160);
      mode = $urandom_range(0, 3);
      repeat (seg) begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
        @(posedge clk);
      end
    end
  end

  // Stimulus and end of run
  initial begin
    in_valid        = 1'b0;
    in_kind         = KIND_ENQUEUE;
    in_block_number = '0;
    in_write_flag   = 1'b0;
    in_request_tag  = '0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = POLICY_FCFS;
    rst_n           = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Nearest-block policy: empty pick, largest seek distance both ways, a tie
    write_policy(POLICY_SSTF);
    pick();                                // empty queue: all-zero result, head stays
    enqueue(BLOCK_MAX, 1'b1, '1);
    pick();                                // distance from head 0 is the largest one
    enqueue('0, 1'b0, '0);
    pick();                                // and back again, head returns to 0
    enqueue(BLOCK_W'(20), 1'b1, PORT_TAG_W'(16'h00a5));
    pick();                                // head now at 20
    enqueue(BLOCK_W'(30), 1'b0, PORT_TAG_W'(16'h5a00));
    enqueue(BLOCK_W'(10), 1'b1, PORT_TAG_W'(16'h8001));
    pick();                                // tie at distance 10: earlier word (30) goes
    pick();

    // Arrival order: fill the queue and push one more to see it rejected
    settle();
    write_policy(POLICY_FCFS);
    for (int i = 0; i <= QUEUE_DEPTH_DEF; i++) begin
      enqueue((i % 2) ? BLOCK_MAX : BLOCK_W'($urandom()), 1'($urandom()), PORT_TAG_W'($urandom()));
    end

    // Random phases, alternating the policy between them
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      write_policy((p % 2 == 0) ? POLICY_SSTF : POLICY_FCFS);
      run_phase(PHASE_WORDS);
    end

    // Drain, then give any stray result time to show up
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("disk_request_scheduler_fcfs_sstf verification clean");
    end else begin
      $display("disk_request_scheduler_fcfs_sstf verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout", $time);
    $display("disk_request_scheduler_fcfs_sstf verification failed");
    $finish;
  end

endmodule
